// ===== hdl/esf_pkg.sv =====
// ----------------------------------------------------------------------------
// esf_pkg
// Types, codes and constants shared by the epoch / sequence command filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package esf_pkg;

  // Request function codes; the unused code behaves as a query
  localparam logic [1:0] FUNC_OFFER = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED     = 3'd0,
    ST_DUPLICATE    = 3'd1,
    ST_OUT_OF_ORDER = 3'd2,
    ST_REJECTED     = 3'd3,
    ST_NONE         = 3'd4
  } status_t;

  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam logic [31:0] AGE_NONE      = 32'hFFFF_FFFF;

  // One request
  typedef struct packed {
    logic [1:0]  func;
    logic        parse_ok;
    logic [31:0] cmd_epoch;
    logic [31:0] cmd_seq;
    logic        cmd_valid;
    logic [31:0] time_ms;
  } cmd_t;

  // One result
  typedef struct packed {
    status_t     status;
    logic [31:0] age_ms;
    logic        is_fresh;
    logic        is_usable;
    logic [31:0] accepted_count;
    logic [31:0] duplicate_count;
    logic [31:0] out_of_order_count;
    logic [31:0] reject_count;
    logic [31:0] epoch_change_count;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/esf_cmd_if.sv =====
// ----------------------------------------------------------------------------
// esf_cmd_if
// Valid / ready channel carrying requests into the command filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface esf_cmd_if;
  logic          valid;
  logic          ready;
  esf_pkg::cmd_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/esf_res_if.sv =====
// ----------------------------------------------------------------------------
// esf_res_if
// Valid / ready channel carrying results out of the command filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface esf_res_if;
  logic          valid;
  logic          ready;
  esf_pkg::res_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hdl/epoch_sequence_command_filter_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_sequence_command_filter_unit
// Single-command duplicate / ordering filter keyed on producer epoch and
// sequence number, with freshness reporting and lifetime counters.
// ----------------------------------------------------------------------------
// Each request passes an input register and a result register: it is held in
// the input register until the result register can take its result, and a new
// request can be taken every cycle while results are drained. The held
// command and the five counters are updated as a request leaves the input
// register, so back-to-back offers see each other's effect. The counters on
// the result port are the live counters, which stay still while a result
// waits to be taken. timeout_ms is written through cfg_wr_en / cfg_wr_data,
// by the user only while the block is idle (the block does not enforce this);
// it resets to 1000 ms, and zero makes every result report not fresh.
`timescale 1ns / 1ps
`default_nettype none

module epoch_sequence_command_filter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  esf_cmd_if.sink          cmd,
  esf_res_if.source        res
);

  // Configuration
  logic [31:0] timeout_ms;

  // Input register
  logic          in_valid;
  esf_pkg::cmd_t in_q;

  // Result register
  logic              out_valid;
  esf_pkg::status_t  out_status;
  logic [31:0]       out_age;
  logic              out_fresh;
  logic              out_usable;

  // Held command and counters
  logic        holds;
  logic [31:0] held_epoch;
  logic [31:0] held_seq;
  logic [31:0] held_arrival;
  logic        held_valid;
  logic [31:0] acc_cnt;
  logic [31:0] dup_cnt;
  logic [31:0] ooo_cnt;
  logic [31:0] rej_cnt;
  logic [31:0] epoch_cnt;

  // Next values
  logic        holds_next;
  logic [31:0] held_epoch_next;
  logic [31:0] held_seq_next;
  logic [31:0] held_arrival_next;
  logic        held_valid_next;
  esf_pkg::status_t status_next;
  logic [31:0] age_next;
  logic        fresh_next;

  logic out_free;
  logic advance;
  logic same_epoch;
  logic take;
  logic epoch_change;

  // Handshake: the result register parts the two sides
  assign out_free  = !out_valid || res.ready;
  assign advance   = in_valid && out_free;
  assign cmd.ready = !in_valid || advance;

  // Timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= esf_pkg::TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_ms <= cfg_wr_data;
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      in_q <= cmd.payload;
    end
  end

  // Classify the request against the held command
  always_comb begin
    same_epoch = holds && (in_q.cmd_epoch == held_epoch);
    if (in_q.func != esf_pkg::FUNC_OFFER) begin
      status_next = esf_pkg::ST_NONE;
    end else if (!in_q.parse_ok) begin
      status_next = esf_pkg::ST_REJECTED;
    end else if (same_epoch && (in_q.cmd_seq == held_seq)) begin
      status_next = esf_pkg::ST_DUPLICATE;
    end else if (same_epoch && (in_q.cmd_seq < held_seq)) begin
      status_next = esf_pkg::ST_OUT_OF_ORDER;
    end else begin
      status_next = esf_pkg::ST_ACCEPTED;
    end
    take         = (status_next == esf_pkg::ST_ACCEPTED);
    epoch_change = take && holds && !same_epoch;
  end

  // Next held command: replace on accept, drop on clear
  always_comb begin
    holds_next        = holds;
    held_epoch_next   = held_epoch;
    held_seq_next     = held_seq;
    held_arrival_next = held_arrival;
    held_valid_next   = held_valid;
    if (in_q.func == esf_pkg::FUNC_CLEAR) begin
      holds_next        = 1'b0;
      held_epoch_next   = '0;
      held_seq_next     = '0;
      held_arrival_next = '0;
      held_valid_next   = 1'b0;
    end else if (take) begin
      holds_next        = 1'b1;
      held_epoch_next   = in_q.cmd_epoch;
      held_seq_next     = in_q.cmd_seq;
      held_arrival_next = in_q.time_ms;
      held_valid_next   = in_q.cmd_valid;
    end
  end

  // Age and freshness after the request has been applied
  always_comb begin
    if (!holds_next) begin
      age_next = esf_pkg::AGE_NONE;
    end else if (in_q.time_ms < held_arrival_next) begin
      age_next = '0;
    end else begin
      age_next = in_q.time_ms - held_arrival_next;
    end
    fresh_next = holds_next && (timeout_ms != '0) && (age_next <= timeout_ms);
  end

  // Advance held command and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      holds        <= 1'b0;
      held_epoch   <= '0;
      held_seq     <= '0;
      held_arrival <= '0;
      held_valid   <= 1'b0;
      acc_cnt      <= '0;
      dup_cnt      <= '0;
      ooo_cnt      <= '0;
      rej_cnt      <= '0;
      epoch_cnt    <= '0;
    end else if (advance) begin
      holds        <= holds_next;
      held_epoch   <= held_epoch_next;
      held_seq     <= held_seq_next;
      held_arrival <= held_arrival_next;
      held_valid   <= held_valid_next;
      if (status_next == esf_pkg::ST_ACCEPTED)     acc_cnt <= acc_cnt + 32'd1;
      if (status_next == esf_pkg::ST_DUPLICATE)    dup_cnt <= dup_cnt + 32'd1;
      if (status_next == esf_pkg::ST_OUT_OF_ORDER) ooo_cnt <= ooo_cnt + 32'd1;
      if (status_next == esf_pkg::ST_REJECTED)     rej_cnt <= rej_cnt + 32'd1;
      if (epoch_change)                             epoch_cnt <= epoch_cnt + 32'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_status <= status_next;
      out_age    <= age_next;
      out_fresh  <= fresh_next;
      out_usable <= fresh_next && held_valid_next;
    end
  end

  // Drive result channel
  assign res.valid                      = out_valid;
  assign res.payload.status             = out_status;
  assign res.payload.age_ms             = out_age;
  assign res.payload.is_fresh           = out_fresh;
  assign res.payload.is_usable          = out_usable;
  assign res.payload.accepted_count     = acc_cnt;
  assign res.payload.duplicate_count    = dup_cnt;
  assign res.payload.out_of_order_count = ooo_cnt;
  assign res.payload.reject_count       = rej_cnt;
  assign res.payload.epoch_change_count = epoch_cnt;

  // Checks
  a_accept_age_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == esf_pkg::ST_ACCEPTED) |-> (out_age == '0))
    else $error("accepted command reports non-zero age");

  a_usable_fresh: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_usable |-> out_fresh)
    else $error("usable result that is not fresh");

  a_clear_drops: assert property (@(posedge clk) disable iff (rst)
    advance && (in_q.func == esf_pkg::FUNC_CLEAR) |=> !holds && !out_fresh)
    else $error("clear left a command held");

  a_counters_still: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(acc_cnt) && $stable(dup_cnt) && $stable(ooo_cnt)
                 && $stable(rej_cnt) && $stable(epoch_cnt))
    else $error("counter moved without a request");

  a_request_kept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid)
    else $error("stalled request lost from input register");

endmodule

`default_nettype wire

// ===== test/tb_epoch_sequence_command_filter_unit.sv =====
// ----------------------------------------------------------------------------
// tb_epoch_sequence_command_filter_unit
// Self-checking bench for the epoch / sequence command filter. Requests run
// through a valid / ready driver with random gaps, and a clocked monitor
// compares every result, field by field, with the filter state tracked here.
// Each timeout setting gets its own phase, written while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_epoch_sequence_command_filter_unit;

  localparam int CYCLE_LIMIT    = 1000000;
  localparam int HOLD_CYCLES    = 400;
  localparam int PHASE_REQUESTS = 385;
  localparam int DRAIN_CYCLES   = 8;
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  esf_cmd_if cmd_ch ();
  esf_res_if res_ch ();

  epoch_sequence_command_filter_unit uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd_ch),
    .res         (res_ch)
  );

  // Requests waiting to be driven and results waiting to come back
  esf_pkg::cmd_t pending_requests[$];
  esf_pkg::res_t expected_results[$];

  // Filter state as this bench tracks it
  logic [31:0] timeout_copy = esf_pkg::TIMEOUT_RESET;
  logic        cmd_held     = 1'b0;
  logic [31:0] held_epoch   = '0;
  logic [31:0] held_seq     = '0;
  logic [31:0] held_arrival = '0;
  logic        held_valid   = 1'b0;
  logic [31:0] accepted_total     = '0;
  logic [31:0] duplicate_total    = '0;
  logic [31:0] out_of_order_total = '0;
  logic [31:0] rejected_total     = '0;
  logic [31:0] epoch_change_total = '0;

  // Producer state for the random part
  logic [31:0] gen_epoch;
  logic [31:0] gen_seq;
  logic [31:0] gen_time;

  int   mismatch_count = 0;
  int   cycle_count    = 0;
  logic cmd_taken      = 1'b0;
  logic sending        = 1'b0;
  int   send_gap       = 0;
  int   send_quiet     = 0;
  int   stall_left     = 0;
  int   recv_quiet     = 0;
  logic hold_request   = 1'b0;
  logic receiver_hold  = 1'b0;
  esf_pkg::res_t got_res;
  esf_pkg::res_t want_res;

  // Clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Update the tracked state for one request and work out its result
  function automatic esf_pkg::res_t filter_predict(esf_pkg::cmd_t c);
    esf_pkg::res_t r;
    logic [31:0]   age;
    logic          fresh;
    r.status = esf_pkg::ST_NONE;
    if (c.func == esf_pkg::FUNC_OFFER) begin
      if (!c.parse_ok) begin
        rejected_total++;
        r.status = esf_pkg::ST_REJECTED;
      end else if (cmd_held && c.cmd_epoch == held_epoch && c.cmd_seq == held_seq) begin
        duplicate_total++;
        r.status = esf_pkg::ST_DUPLICATE;
      end else if (cmd_held && c.cmd_epoch == held_epoch && c.cmd_seq < held_seq) begin
        out_of_order_total++;
        r.status = esf_pkg::ST_OUT_OF_ORDER;
      end else begin
        if (cmd_held && c.cmd_epoch != held_epoch) epoch_change_total++;
        cmd_held     = 1'b1;
        held_epoch   = c.cmd_epoch;
        held_seq     = c.cmd_seq;
        held_valid   = c.cmd_valid;
        held_arrival = c.time_ms;
        accepted_total++;
        r.status = esf_pkg::ST_ACCEPTED;
      end
    end else if (c.func == esf_pkg::FUNC_CLEAR) begin
      cmd_held     = 1'b0;
      held_epoch   = '0;
      held_seq     = '0;
      held_arrival = '0;
      held_valid   = 1'b0;
    end
    if (!cmd_held) age = esf_pkg::AGE_NONE;
    else if (c.time_ms < held_arrival) age = '0;
    else age = c.time_ms - held_arrival;
    fresh = cmd_held && timeout_copy != 0 && age <= timeout_copy;
    r.age_ms             = age;
    r.is_fresh           = fresh;
    r.is_usable          = fresh && held_valid;
    r.accepted_count     = accepted_total;
    r.duplicate_count    = duplicate_total;
    r.out_of_order_count = out_of_order_total;
    r.reject_count       = rejected_total;
    r.epoch_change_count = epoch_change_total;
    return r;
  endfunction

  // Random idle length: mostly none, a few long, with quiet stretches
  function automatic int pick_gap(inout int quiet_left);
    int roll;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      quiet_left = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_request(logic [1:0] func, logic ok, logic [31:0] epoch,
                               logic [31:0] seq, logic vld, logic [31:0] t);
    esf_pkg::cmd_t c;
    c.func      = func;
    c.parse_ok  = ok;
    c.cmd_epoch = epoch;
    c.cmd_seq   = seq;
    c.cmd_valid = vld;
    c.time_ms   = t;
    pending_requests.push_back(c);
  endtask

  // Mostly well-formed producer traffic, with restarts, replays and noise
  task automatic queue_random_requests(int count);
    int          roll;
    logic [31:0] spread;
    for (int i = 0; i < count; i++) begin
      spread = (timeout_copy == 0 || timeout_copy > 32'd4000) ? 32'd2000
                                                             : timeout_copy * 2 + 2;
      if ($urandom_range(0, 19) == 0) gen_time = gen_time - $urandom_range(1, spread);
      else if ($urandom_range(0, 49) == 0) gen_time = $urandom;
      else gen_time = gen_time + $urandom_range(0, spread);
      roll = $urandom_range(0, 99);
      if (roll < 50) begin
        gen_seq = gen_seq + $urandom_range(1, 3);
        queue_request(esf_pkg::FUNC_OFFER, 1'b1, gen_epoch, gen_seq,
                      1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 60) begin
        queue_request(esf_pkg::FUNC_OFFER, 1'b1, gen_epoch, gen_seq,
                      1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 67) begin
        queue_request(esf_pkg::FUNC_OFFER, 1'b1, gen_epoch, gen_seq - $urandom_range(1, 5),
                      1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 72) begin
        gen_epoch = $urandom_range(0, 1) ? gen_epoch + 1 : $urandom;
        gen_seq   = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom;
        queue_request(esf_pkg::FUNC_OFFER, 1'b1, gen_epoch, gen_seq,
                      1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 79) begin
        queue_request(esf_pkg::FUNC_OFFER, 1'b0, $urandom_range(0, 1) ? gen_epoch : $urandom,
                      gen_seq + $urandom_range(0, 2), 1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 91) begin
        queue_request(esf_pkg::FUNC_QUERY, 1'($urandom_range(0, 1)), $urandom, $urandom,
                      1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 95) begin
        queue_request(FUNC_SPARE, 1'($urandom_range(0, 1)), $urandom, $urandom,
                      1'($urandom_range(0, 1)), gen_time);
      end else if (roll < 97) begin
        queue_request(esf_pkg::FUNC_CLEAR, 1'($urandom_range(0, 1)), $urandom, $urandom,
                      1'($urandom_range(0, 1)), gen_time);
      end else begin
        queue_request(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom,
                      $urandom, 1'($urandom_range(0, 1)), $urandom);
      end
    end
  endtask

  // Hold until every request is sent and every result is back
  task automatic wait_idle();
    while (pending_requests.size() > 0 || sending || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    timeout_copy = value;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
    end
  endtask

  // Request driver: advance to the next request once the current one is taken
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      sending = 1'b0;
    end else if (!sending || cmd_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        cmd_ch.valid <= 1'b0;
        sending = 1'b0;
      end else if (pending_requests.size() > 0) begin
        cmd_ch.payload <= pending_requests.pop_front();
        cmd_ch.valid   <= 1'b1;
        sending = 1'b1;
        send_gap = pick_gap(send_quiet);
      end else begin
        cmd_ch.valid <= 1'b0;
        sending = 1'b0;
      end
    end
  end

  // Result receiver: random stalls, or a long hold-off when asked
  always @(negedge clk) begin
    if (rst || receiver_hold) begin
      res_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      stall_left = pick_gap(recv_quiet);
    end
  end

  // Long hold-off on the result side while requests keep coming
  initial begin
    wait (hold_request);
    @(negedge clk);
    receiver_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    receiver_hold = 1'b0;
  end

  // Monitor: predict each accepted request, check each accepted result
  always @(posedge clk) begin
    if (rst) begin
      cmd_taken <= 1'b0;
    end else begin
      cmd_taken <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready)
        expected_results.push_back(filter_predict(cmd_ch.payload));
      if (res_ch.valid && res_ch.ready) begin
        got_res = res_ch.payload;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with nothing expected, status %0d", $realtime,
                     got_res.status);
        end else begin
          want_res = expected_results.pop_front();
          check_field("status", 32'(want_res.status), 32'(got_res.status));
          check_field("age_ms", want_res.age_ms, got_res.age_ms);
          check_field("is_fresh", 32'(want_res.is_fresh), 32'(got_res.is_fresh));
          check_field("is_usable", 32'(want_res.is_usable), 32'(got_res.is_usable));
          check_field("accepted_count", want_res.accepted_count, got_res.accepted_count);
          check_field("duplicate_count", want_res.duplicate_count, got_res.duplicate_count);
          check_field("out_of_order_count", want_res.out_of_order_count,
                      got_res.out_of_order_count);
          check_field("reject_count", want_res.reject_count, got_res.reject_count);
          check_field("epoch_change_count", want_res.epoch_change_count,
                      got_res.epoch_change_count);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Stimulus
  initial begin
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    cmd_ch.valid   = 1'b0;
    cmd_ch.payload = '0;
    res_ch.ready   = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part at the reset timeout of 1000 ms
    queue_request(esf_pkg::FUNC_QUERY, 1'b1, 32'd0, 32'd0, 1'b0, 32'd0);      // nothing held
    queue_request(esf_pkg::FUNC_OFFER, 1'b0, 32'd5, 32'd10, 1'b1, 32'd100);  // parse failed
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'd5, 32'd10, 1'b1, 32'd100);  // first command
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'd5, 32'd10, 1'b1, 32'd200);  // duplicate
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'd5, 32'd9, 1'b1, 32'd300);   // out of order
    queue_request(esf_pkg::FUNC_QUERY, 1'b0, 32'd0, 32'd0, 1'b0, 32'd1100);  // age at timeout
    queue_request(esf_pkg::FUNC_QUERY, 1'b0, 32'd0, 32'd0, 1'b0, 32'd1101);  // just stale
    queue_request(esf_pkg::FUNC_QUERY, 1'b0, 32'd0, 32'd0, 1'b0, 32'd50);    // clock stepped back
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'd5, 32'd11, 1'b0, 32'd2000); // fresh, not usable
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'hFFFF_FFFF, 32'd0, 1'b1,
                  32'd2000);                                                  // epoch change
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                  32'hFFFF_FFFF);
    queue_request(FUNC_SPARE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'd0);
    queue_request(esf_pkg::FUNC_CLEAR, 1'b1, 32'd0, 32'd0, 1'b1, 32'd5);
    queue_request(esf_pkg::FUNC_QUERY, 1'b1, 32'd0, 32'd0, 1'b1,
                  32'hFFFF_FFFF);                                             // after clear
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'd0, 32'd0, 1'b1, 32'd0);     // first again
    queue_request(esf_pkg::FUNC_OFFER, 1'b0, 32'd0, 32'd0, 1'b1, 32'd0);     // rejected, not dup
    queue_request(esf_pkg::FUNC_OFFER, 1'b1, 32'd1, 32'hFFFF_FFFF, 1'b0,
                  32'd7);                                                     // epoch change
    queue_request(esf_pkg::FUNC_QUERY, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                  32'hFFFF_FFFF);
    queue_request(esf_pkg::FUNC_CLEAR, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0,
                  32'hFFFF_FFFF);

    gen_epoch = $urandom;
    gen_seq   = $urandom_range(0, 100);
    gen_time  = $urandom;

    // Random phases over a spread of timeout settings
    write_timeout(32'd0);
    queue_random_requests(PHASE_REQUESTS);
    hold_request = 1'b1;
    write_timeout(32'hFFFF_FFFF);
    queue_random_requests(PHASE_REQUESTS);
    write_timeout(32'd1);
    queue_random_requests(PHASE_REQUESTS);
    write_timeout($urandom_range(2, 3000));
    queue_random_requests(PHASE_REQUESTS);
    write_timeout(esf_pkg::TIMEOUT_RESET);
    queue_random_requests(PHASE_REQUESTS);

    wait_idle();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/esf_pkg.sv
hdl/esf_cmd_if.sv
hdl/esf_res_if.sv
hdl/epoch_sequence_command_filter_unit.sv
test/tb_epoch_sequence_command_filter_unit.sv
